/* rtl/gpc_pkg.sv */
// ----------------------------------------------------------------------------
// gpc_pkg: shared widths for the gcd pair counter.
// Holds the field widths that the ports of the block use.
// ----------------------------------------------------------------------------
package gpc_pkg;
  localparam int unsigned FIELD_W = 18;
  localparam int unsigned COUNT_W = 35;
endpackage

/* rtl/gpc_divider.sv */
// ----------------------------------------------------------------------------
// gpc_divider: shared restoring divider, one quotient bit per cycle.
// Divides a numerator by a divisor; the remainder is dropped.
// ----------------------------------------------------------------------------
module gpc_divider #(
  parameter int unsigned W = 21
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  q;
  logic [W-1:0]  d;
  logic [CW-1:0] cnt;
  logic          run;
  logic [W:0]    trial;

  // One trial subtraction per cycle.
  assign trial = {rem, q[W-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        rem <= '0;
        q <= num;
        d <= den;
        cnt <= CW'(W);
      end else if (run) begin
        if (trial[W]) begin
          rem <= {rem[W-2:0], q[W-1]};
          q <= {q[W-2:0], 1'b0};
        end else begin
          rem <= trial[W-1:0];
          q <= {q[W-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;
endmodule

/* rtl/gcd_pair_counter.sv */
// ----------------------------------------------------------------------------
// gcd_pair_counter: counts unordered pairs with a given greatest common divisor.
// Iterative inclusion-exclusion over a smallest-prime-factor table.
// ----------------------------------------------------------------------------
// Usage: raise start with first_bound, second_bound and divisor while busy is
// low; the item is taken at that edge and busy rises. When the count is ready,
// done strobes for one cycle with pair_count valid, and busy falls. The
// receiver cannot stall; the result is shown once only.
// After reset a clearing pass zeroes the factor table, then the sieve fills it:
// each value is read, and each prime is written at itself and at every
// unmarked multiple from its square. Busy stays high meanwhile.
// Every division goes through one shared bit-serial divider of
// max($clog2(VALUE_LIMIT+1), FIELD_W) bits. A query with a nonzero divisor
// costs two divisions for the quotients, then for every i up to the smaller
// quotient one table read per distinct prime, one division per prime factor
// plus one per distinct prime, and two divisions per nonempty subset of its
// distinct primes whose product stays within the larger quotient. One item is
// in work at a time.
// ----------------------------------------------------------------------------
module gcd_pair_counter #(
  parameter int unsigned VALUE_LIMIT = 131072,
  parameter int unsigned MAX_PRIMES  = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [gpc_pkg::FIELD_W-1:0]  first_bound,
  input  logic [gpc_pkg::FIELD_W-1:0]  second_bound,
  input  logic [gpc_pkg::FIELD_W-1:0]  divisor,
  output logic                         done,
  output logic [gpc_pkg::COUNT_W-1:0]  pair_count
);
  localparam int unsigned VW = $clog2(VALUE_LIMIT + 1);
  localparam int unsigned DW = (VW > gpc_pkg::FIELD_W) ? VW : gpc_pkg::FIELD_W;
  localparam int unsigned CW = gpc_pkg::COUNT_W;
  localparam int unsigned PW = $clog2(MAX_PRIMES + 1);
  localparam int unsigned SW = MAX_PRIMES;
  localparam int unsigned DEPTH = VALUE_LIMIT + 1;

  typedef enum logic [4:0] {
    S_CLR, S_SV_CHK, S_SV_RD, S_SV_MUL, S_SV_MARK, S_SV_W,
    S_IDLE, S_DIV_N, S_DIV_M, S_ORDER,
    S_I_BEGIN, S_F_RD, S_F_WAIT, S_F_DIV, S_F_CHK,
    S_SUB_BEGIN, S_SUB_MUL, S_SUB_DM, S_SUB_DI, S_SUB_ACC, S_NEXT_I, S_OUT
  } state_t;

  state_t state;

  // Factor table, one write and one registered read port.
  logic [VW-1:0] sf_mem [DEPTH];
  logic [VW-1:0] sf_rd;
  logic [VW-1:0] rd_addr;
  logic [VW-1:0] wr_addr;
  logic [VW-1:0] wr_data;
  logic          wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) sf_mem[wr_addr] <= wr_data;
    sf_rd <= sf_mem[rd_addr];
  end

  // Shared divider.
  logic          dv_go;
  logic [DW-1:0] dv_num;
  logic [DW-1:0] dv_den;
  logic          dv_done;
  logic [DW-1:0] dv_quo;

  gpc_divider #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .go(dv_go), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo)
  );

  logic [VW-1:0] v;
  logic [VW:0]   w;
  logic [VW-1:0] n;
  logic [VW-1:0] m;
  logic [VW-1:0] i;
  logic [VW-1:0] rest;
  logic [VW-1:0] p;
  logic [VW-1:0] primes [MAX_PRIMES];
  logic [PW-1:0] np;
  logic [SW:0]   s;
  logic [2*VW-1:0] prod;
  logic [PW-1:0] q;
  logic          odd;
  logic [VW-1:0] qm;
  logic [CW-1:0] total;
  logic [VW-1:0] fb_c;
  logic [VW-1:0] sb_c;

  // Clamp the bounds to the table limit.
  assign fb_c = (DW'(first_bound) > DW'(VALUE_LIMIT))
              ? VW'(VALUE_LIMIT) : VW'(first_bound);
  assign sb_c = (DW'(second_bound) > DW'(VALUE_LIMIT))
              ? VW'(VALUE_LIMIT) : VW'(second_bound);

  assign busy = (state != S_IDLE);

  // Read address and write port are driven from the sequencer.
  always_comb begin
    rd_addr = rest;
    wr_en = 1'b0;
    wr_addr = v;
    wr_data = '0;
    unique case (state)
      S_CLR: begin
        wr_en = 1'b1;
        wr_addr = v;
        wr_data = '0;
      end
      S_SV_CHK: rd_addr = v;
      S_SV_MARK: rd_addr = w[VW-1:0];
      S_SV_W: begin
        wr_en = (sf_rd == '0) || (w[VW-1:0] == v);
        wr_addr = w[VW-1:0];
        wr_data = v;
      end
      default: ;
    endcase
  end

  // Sequencer: clear and sieve the table after reset, then queries.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      v <= '0;
      done <= 1'b0;
      dv_go <= 1'b0;
      total <= '0;
    end else begin
      done <= 1'b0;
      dv_go <= 1'b0;
      unique case (state)
        S_CLR: begin
          if (v == VW'(VALUE_LIMIT)) begin
            v <= VW'(2);
            state <= S_SV_CHK;
          end else begin
            v <= v + 1'b1;
          end
        end
        S_SV_CHK: state <= S_SV_RD;
        S_SV_RD: begin
          if (sf_rd != '0) begin
            if (v == VW'(VALUE_LIMIT)) state <= S_IDLE;
            else begin
              v <= v + 1'b1;
              state <= S_SV_CHK;
            end
          end else begin
            w <= {1'b0, v};
            state <= S_SV_MARK;
          end
        end
        S_SV_MARK: state <= S_SV_W;
        S_SV_W: begin
          // First pass writes v itself, then multiples from v*v.
          if (w[VW-1:0] == v) begin
            w <= (VW+1)'((2*VW)'(v) * (2*VW)'(v) > (2*VW)'(VALUE_LIMIT)
                 ? VALUE_LIMIT + 1 : v * v);
          end else begin
            w <= w + {1'b0, v};
          end
          state <= S_SV_MUL;
        end
        S_SV_MUL: begin
          if (w > (VW+1)'(VALUE_LIMIT)) begin
            if (v == VW'(VALUE_LIMIT)) state <= S_IDLE;
            else begin
              v <= v + 1'b1;
              state <= S_SV_CHK;
            end
          end else begin
            state <= S_SV_MARK;
          end
        end
        S_IDLE: begin
          if (start) begin
            total <= '0;
            n <= fb_c;
            m <= sb_c;
            if (divisor == '0) state <= S_OUT;
            else begin
              dv_num <= DW'(fb_c);
              dv_den <= DW'(divisor);
              dv_go <= 1'b1;
              state <= S_DIV_N;
            end
          end
        end
        S_DIV_N: begin
          if (dv_done) begin
            n <= VW'(dv_quo);
            dv_num <= DW'(m);
            dv_go <= 1'b1;
            state <= S_DIV_M;
          end
        end
        S_DIV_M: begin
          if (dv_done) begin
            m <= VW'(dv_quo);
            state <= S_ORDER;
          end
        end
        S_ORDER: begin
          if (n == '0 || m == '0) state <= S_OUT;
          else begin
            if (n > m) begin
              n <= m;
              m <= n;
              total <= CW'(n);
            end else begin
              total <= CW'(m);
            end
            i <= VW'(2);
            state <= S_I_BEGIN;
          end
        end
        S_I_BEGIN: begin
          if (i > n) state <= S_OUT;
          else begin
            total <= total + CW'(m - i);
            rest <= i;
            np <= '0;
            state <= S_F_RD;
          end
        end
        // Factor rest through the table.
        S_F_RD: begin
          if (rest <= VW'(1)) begin
            s <= (SW+1)'(1);
            state <= S_SUB_BEGIN;
          end else state <= S_F_WAIT;
        end
        S_F_WAIT: begin
          p <= (sf_rd < VW'(2) || sf_rd > rest) ? rest : sf_rd;
          if (np < PW'(MAX_PRIMES)) begin
            primes[np[$clog2(MAX_PRIMES)-1:0]] <=
              (sf_rd < VW'(2) || sf_rd > rest) ? rest : sf_rd;
            np <= np + 1'b1;
          end
          state <= S_F_DIV;
        end
        S_F_DIV: begin
          dv_num <= DW'(rest);
          dv_den <= DW'(p);
          dv_go <= 1'b1;
          state <= S_F_CHK;
        end
        S_F_CHK: begin
          if (dv_done) begin
            if (VW'(dv_quo) * p == rest) begin
              rest <= VW'(dv_quo);
              state <= S_F_DIV;
            end else state <= S_F_RD;
          end
        end
        // Walk the subsets; the product is built one prime per cycle.
        S_SUB_BEGIN: begin
          if (s >= ((SW+1)'(1) << np)) state <= S_NEXT_I;
          else begin
            prod <= (2*VW)'(1);
            q <= '0;
            odd <= 1'b0;
            state <= S_SUB_MUL;
          end
        end
        S_SUB_MUL: begin
          if (q == np) begin
            if (prod > (2*VW)'(m)) begin
              s <= s + 1'b1;
              state <= S_SUB_BEGIN;
            end else begin
              dv_num <= DW'(m);
              dv_den <= DW'(prod);
              dv_go <= 1'b1;
              state <= S_SUB_DM;
            end
          end else begin
            if (s[q[$clog2(SW+1)-1:0]]) begin
              prod <= (prod > (2*VW)'(VALUE_LIMIT)) ? prod
                    : (2*VW)'(prod[VW-1:0] * primes[q[$clog2(MAX_PRIMES)-1:0]]);
              odd <= ~odd;
            end
            q <= q + 1'b1;
          end
        end
        S_SUB_DM: begin
          if (dv_done) begin
            qm <= VW'(dv_quo);
            dv_num <= DW'(i);
            dv_go <= 1'b1;
            state <= S_SUB_DI;
          end
        end
        S_SUB_DI: begin
          if (dv_done) begin
            if (odd) total <= total - CW'(qm - VW'(dv_quo));
            else     total <= total + CW'(qm - VW'(dv_quo));
            state <= S_SUB_ACC;
          end
        end
        S_SUB_ACC: begin
          s <= s + 1'b1;
          state <= S_SUB_BEGIN;
        end
        S_NEXT_I: begin
          if (i == n) state <= S_OUT;
          else begin
            i <= i + 1'b1;
            state <= S_I_BEGIN;
          end
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pair_count = total;

`ifndef NO_ASSERTIONS
  // A result strobe is never given while idle was held the cycle before.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without a query in work");
  // After a result, the block is ready.
  a_ready_after_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy after done");
  // A taken item raises busy.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item not taken");
`endif
endmodule
